// ===== hdl/tcgr_pkg.sv =====
package tcgr_pkg;

	// Glyph geometry and cursor widths
	localparam int GLYPH_COLUMNS = 6;
	localparam int GLYPH_ROWS    = 8;
	localparam int GLYPH_COUNT   = 95;
	localparam int COL_W         = $clog2(GLYPH_COLUMNS);
	localparam int ROW_W         = $clog2(GLYPH_ROWS);
	localparam int GLYPH_W       = $clog2(GLYPH_COUNT);
	localparam int CUR_W         = 12;
	localparam int POS_W         = 14;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

	// Character codes
	localparam logic [7:0] CODE_LF    = 8'h0A;
	localparam logic [7:0] CODE_CR    = 8'h0D;
	localparam logic [7:0] CODE_FIRST = 8'h20;
	localparam logic [7:0] CODE_LAST  = 8'h7E;

	// Register reset values
	localparam logic [8:0]  PANEL_WIDTH  = 9'd240;
	localparam logic [8:0]  PANEL_HEIGHT = 9'd320;
	localparam logic [15:0] FG_RESET     = 16'hFFFF;
	localparam logic [15:0] BG_RESET     = 16'h0000;
	localparam logic [3:0]  SCALE_RESET  = 4'd1;

	// Job queue between front and back
	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
	localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_ACTIVE_W    = 3'd0,
		REG_ACTIVE_H    = 3'd1,
		REG_FG_COLOR    = 3'd2,
		REG_PAPER_COLOR = 3'd3,
		REG_SCALE       = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [8:0]  active_w;
		logic [8:0]  active_h;
		logic [15:0] fg_color;
		logic [15:0] paper_color;
		logic [3:0]  scale;
	} cfg_t;

	typedef struct packed {
		logic [GLYPH_W-1:0]      glyph;
		logic signed [CUR_W-1:0] col0;
		logic signed [CUR_W-1:0] row0;
		logic signed [CUR_W-1:0] col_next;
		logic signed [CUR_W-1:0] row_next;
	} job_t;

	typedef struct packed {
		logic [8:0]              x;
		logic [8:0]              y;
		logic [3:0]              w;
		logic [3:0]              h;
		logic [15:0]             color;
		logic signed [CUR_W-1:0] col_after;
		logic signed [CUR_W-1:0] row_after;
		logic                    last;
	} rect_t;

	// Clamp a widened cursor sum to the 12-bit signed range
	function automatic logic signed [CUR_W-1:0] sat_cursor(input logic signed [POS_W-1:0] v);
		logic signed [POS_W-1:0] hi;
		logic signed [POS_W-1:0] lo;
		hi = POS_W'(2047);
		lo = -POS_W'(2048);
		if (v > hi) begin
			return CUR_W'(2047);
		end else if (v < lo) begin
			return -CUR_W'(2048);
		end
		return v[CUR_W-1:0];
	endfunction

	// 6x8 font, one byte per column, bit r is row r
	localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT-1][0:GLYPH_COLUMNS-1] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14,8'h00},
		'{8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00}, '{8'h23,8'h13,8'h08,8'h64,8'h62,8'h00},
		'{8'h36,8'h49,8'h55,8'h22,8'h50,8'h00}, '{8'h00,8'h05,8'h03,8'h00,8'h00,8'h00},
		'{8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00,8'h00},
		'{8'h14,8'h08,8'h3E,8'h08,8'h14,8'h00}, '{8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00},
		'{8'h00,8'h50,8'h30,8'h00,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08,8'h00},
		'{8'h00,8'h60,8'h60,8'h00,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02,8'h00},
		'{8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00}, '{8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46,8'h00}, '{8'h21,8'h41,8'h45,8'h4B,8'h31,8'h00},
		'{8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00}, '{8'h27,8'h45,8'h45,8'h45,8'h39,8'h00},
		'{8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00}, '{8'h01,8'h71,8'h09,8'h05,8'h03,8'h00},
		'{8'h36,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00},
		'{8'h00,8'h36,8'h36,8'h00,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00,8'h00},
		'{8'h08,8'h14,8'h22,8'h41,8'h00,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h00},
		'{8'h41,8'h22,8'h14,8'h08,8'h00,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06,8'h00},
		'{8'h32,8'h49,8'h79,8'h41,8'h3E,8'h00}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h00},
		'{8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00},
		'{8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00}, '{8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00},
		'{8'h7F,8'h09,8'h09,8'h09,8'h01,8'h00}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A,8'h00},
		'{8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00}, '{8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00},
		'{8'h20,8'h40,8'h41,8'h3F,8'h01,8'h00}, '{8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00},
		'{8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F,8'h00},
		'{8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00},
		'{8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00},
		'{8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00}, '{8'h46,8'h49,8'h49,8'h49,8'h31,8'h00},
		'{8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00},
		'{8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F,8'h00},
		'{8'h63,8'h14,8'h08,8'h14,8'h63,8'h00}, '{8'h07,8'h08,8'h70,8'h08,8'h07,8'h00},
		'{8'h61,8'h51,8'h49,8'h45,8'h43,8'h00}, '{8'h00,8'h7F,8'h41,8'h41,8'h00,8'h00},
		'{8'h02,8'h04,8'h08,8'h10,8'h20,8'h00}, '{8'h00,8'h41,8'h41,8'h7F,8'h00,8'h00},
		'{8'h04,8'h02,8'h01,8'h02,8'h04,8'h00}, '{8'h40,8'h40,8'h40,8'h40,8'h40,8'h00},
		'{8'h00,8'h01,8'h02,8'h04,8'h00,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78,8'h00},
		'{8'h7F,8'h48,8'h44,8'h44,8'h38,8'h00}, '{8'h38,8'h44,8'h44,8'h44,8'h20,8'h00},
		'{8'h38,8'h44,8'h44,8'h48,8'h7F,8'h00}, '{8'h38,8'h54,8'h54,8'h54,8'h18,8'h00},
		'{8'h08,8'h7E,8'h09,8'h01,8'h02,8'h00}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E,8'h00},
		'{8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00}, '{8'h00,8'h44,8'h7D,8'h40,8'h00,8'h00},
		'{8'h20,8'h40,8'h44,8'h3D,8'h00,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00,8'h00},
		'{8'h00,8'h41,8'h7F,8'h40,8'h00,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00},
		'{8'h7C,8'h08,8'h04,8'h04,8'h78,8'h00}, '{8'h38,8'h44,8'h44,8'h44,8'h38,8'h00},
		'{8'h7C,8'h14,8'h14,8'h14,8'h08,8'h00}, '{8'h08,8'h14,8'h14,8'h18,8'h7C,8'h00},
		'{8'h7C,8'h08,8'h04,8'h04,8'h08,8'h00}, '{8'h48,8'h54,8'h54,8'h54,8'h20,8'h00},
		'{8'h04,8'h3F,8'h44,8'h40,8'h20,8'h00}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C,8'h00},
		'{8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h00},
		'{8'h44,8'h28,8'h10,8'h28,8'h44,8'h00}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C,8'h00},
		'{8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00}, '{8'h00,8'h08,8'h36,8'h41,8'h00,8'h00},
		'{8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00,8'h00},
		'{8'h08,8'h08,8'h2A,8'h1C,8'h08,8'h00}
	};

endpackage

// ===== hdl/tcgr_front.sv =====
module tcgr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tcgr_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [7:0]                       char_code,
	input  logic signed [tcgr_pkg::CUR_W-1:0] set_x,
	input  logic signed [tcgr_pkg::CUR_W-1:0] set_y,
	input  logic                             jobq_full,
	output logic                             jobq_push,
	output tcgr_pkg::job_t                   jobq_data
);
	import tcgr_pkg::*;

	logic signed [CUR_W-1:0] cur_col_q;
	logic signed [CUR_W-1:0] cur_row_q;

	logic                    accept;
	logic                    is_lf;
	logic                    is_cr;
	logic                    printable;
	logic [6:0]              step_col;
	logic [6:0]              step_row;
	logic signed [POS_W-1:0] col_sum;
	logic signed [POS_W-1:0] row_sum;
	logic signed [CUR_W-1:0] col_adv;
	logic signed [CUR_W-1:0] row_adv;
	logic                    wrap;
	logic signed [CUR_W-1:0] col_next;
	logic signed [CUR_W-1:0] row_next;
	logic [GLYPH_W-1:0]      glyph;

	// Handshake: the queue is the only thing that can hold off a beat
	assign in_stall = jobq_full;
	assign accept   = in_valid && !jobq_full;

	// Classify the character
	assign is_lf     = (char_code == CODE_LF);
	assign is_cr     = (char_code == CODE_CR);
	assign printable = (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
	assign glyph     = printable ? GLYPH_W'(char_code - CODE_FIRST) : '0;

	// Advance by 6*scale columns, new line is 8*scale rows
	assign step_col = 7'({cfg.scale, 2'b00}) + 7'({cfg.scale, 1'b0});
	assign step_row = 7'({cfg.scale, 3'b000});
	assign col_sum  = $signed({{(POS_W-CUR_W){cur_col_q[CUR_W-1]}}, cur_col_q})
		+ $signed({{(POS_W-7){1'b0}}, step_col});
	assign row_sum  = $signed({{(POS_W-CUR_W){cur_row_q[CUR_W-1]}}, cur_row_q})
		+ $signed({{(POS_W-7){1'b0}}, step_row});
	assign col_adv  = sat_cursor(col_sum);
	assign row_adv  = sat_cursor(row_sum);

	// Wrap once the advanced column reaches the screen width
	assign wrap     = $signed({{(POS_W-CUR_W){col_adv[CUR_W-1]}}, col_adv})
		>= $signed({{(POS_W-9){1'b0}}, cfg.active_w});
	assign col_next = wrap ? '0 : col_adv;
	assign row_next = wrap ? row_adv : cur_row_q;

	// Each character but LF or CR is a job, unprintable as glyph 0
	assign jobq_push = accept && !cmd && !is_lf && !is_cr;
	always_comb begin
		jobq_data          = '0;
		jobq_data.glyph    = glyph;
		jobq_data.col0     = cur_col_q;
		jobq_data.row0     = cur_row_q;
		jobq_data.col_next = col_next;
		jobq_data.row_next = row_next;
	end

	// Cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (accept) begin
			if (cmd) begin
				cur_col_q <= set_x;
				cur_row_q <= set_y;
			end else if (is_lf) begin
				cur_col_q <= '0;
				cur_row_q <= row_adv;
			end else if (is_cr) begin
				cur_col_q <= '0;
			end else begin
				cur_col_q <= col_next;
				cur_row_q <= row_next;
			end
		end
	end

endmodule

// ===== hdl/tcgr_jobq.sv =====
module tcgr_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcgr_pkg::job_t push_data,
	input  logic           pop,
	output tcgr_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import tcgr_pkg::*;

	job_t                  slot_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_W-1:0] wr_ptr_q;
	logic [JOBQ_PTR_W-1:0] rd_ptr_q;
	logic [JOBQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == JOBQ_CNT_W'(JOBQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	function automatic logic [JOBQ_PTR_W-1:0] next_ptr(input logic [JOBQ_PTR_W-1:0] p);
		return (p == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/tcgr_back.sv =====
module tcgr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tcgr_pkg::cfg_t cfg,
	input  logic           jobq_empty,
	input  tcgr_pkg::job_t jobq_head,
	output logic           jobq_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output tcgr_pkg::rect_t out_rect
);
	import tcgr_pkg::*;

	// Cell walker
	job_t                    job_q;
	logic                    busy_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;

	// One rectangle held back until we know whether it is the item's last
	logic                    pend_valid_q;
	rect_t                   pend_q;

	// Output register
	logic                    out_valid_q;
	rect_t                   out_q;

	logic                    final_cell;
	logic [7:0]              col_bits;
	logic                    cell_on;
	logic signed [POS_W-1:0] sw;
	logic signed [POS_W-1:0] sh;
	logic signed [POS_W-1:0] step;
	logic signed [POS_W-1:0] dx;
	logic signed [POS_W-1:0] dy;
	logic                    px_ok;
	logic                    py_ok;
	logic                    cand_ok;
	rect_t                   cand;
	logic                    out_free;
	logic                    adv;
	logic                    pend_go;
	logic                    load;

	assign sw   = $signed({{(POS_W-9){1'b0}}, cfg.active_w});
	assign sh   = $signed({{(POS_W-9){1'b0}}, cfg.active_h});
	assign step = $signed({{(POS_W-4){1'b0}}, cfg.scale});

	// Evaluate the current cell
	assign final_cell = (col_q == COL_LAST) && (row_q == ROW_LAST);
	assign col_bits   = FONT_ROM[job_q.glyph][col_q];
	assign cell_on    = col_bits[row_q];
	assign px_ok      = !px_q[POS_W-1] && (px_q < sw);
	assign py_ok      = !py_q[POS_W-1] && (py_q < sh);
	assign dx         = sw - px_q;
	assign dy         = sh - py_q;
	assign cand_ok    = busy_q && (cell_on || (cfg.paper_color != cfg.fg_color))
		&& (cfg.scale != '0) && px_ok && py_ok;

	// Clip at the right and bottom edges
	always_comb begin
		cand           = '0;
		cand.x         = px_q[8:0];
		cand.y         = py_q[8:0];
		cand.w         = (dx <= step) ? dx[3:0] : cfg.scale;
		cand.h         = (dy <= step) ? dy[3:0] : cfg.scale;
		cand.color     = cell_on ? cfg.fg_color : cfg.paper_color;
		cand.col_after = job_q.col_next;
		cand.row_after = job_q.row_next;
		cand.last      = final_cell;
	end

	// Flow control: the walker stalls only when a new rectangle must push the
	// pending one out and the output register is still full
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = busy_q && (!cand_ok || !pend_valid_q || out_free);
	assign pend_go  = pend_valid_q && out_free && (pend_q.last || (adv && cand_ok));
	assign load     = !jobq_empty && (!busy_q || (adv && final_cell));
	assign jobq_pop = load;

	// Walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			col_q  <= '0;
			row_q  <= '0;
		end else if (adv) begin
			if (final_cell) begin
				busy_q <= 1'b0;
			end else if (row_q == ROW_LAST) begin
				row_q <= '0;
				col_q <= col_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// Walker positions and job snapshot
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= jobq_head;
			px_q  <= $signed({{(POS_W-CUR_W){jobq_head.col0[CUR_W-1]}}, jobq_head.col0});
			py_q  <= $signed({{(POS_W-CUR_W){jobq_head.row0[CUR_W-1]}}, jobq_head.row0});
		end else if (adv) begin
			if (row_q == ROW_LAST) begin
				px_q <= px_q + step;
				py_q <= $signed({{(POS_W-CUR_W){job_q.row0[CUR_W-1]}}, job_q.row0});
			end else begin
				py_q <= py_q + step;
			end
		end
	end

	// Pending rectangle valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (adv && cand_ok) begin
			pend_valid_q <= 1'b1;
		end else if (pend_go) begin
			pend_valid_q <= 1'b0;
		end
	end

	// Pending rectangle payload; marked last when its item ends without a successor
	always_ff @(posedge clk) begin
		if (adv && cand_ok) begin
			pend_q <= cand;
		end else if (!pend_go && adv && final_cell && pend_valid_q) begin
			pend_q.last <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_go) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rect  = out_q;

endmodule

// ===== hdl/text_cursor_glyph_renderer.sv =====
// Text renderer: turns characters into fill rectangles at a text cursor.
// Input channel (in_valid/in_stall): one beat is either a set-cursor command
// (cmd=1, set_x/set_y) or a character (cmd=0, char_code). Line feed, carriage
// return and set-cursor only move the cursor and produce no rectangles.
// Output channel (out_valid/out_stall): one beat per rectangle, up to 48 per
// character, column by column and top row first; last marks the final one.
// Each beat also carries the cursor as it stands after that character.
// Throughput: the cell walker takes one font cell per cycle, whether or not
// that cell yields a rectangle, and holds only while a full output stalls it;
// back-to-back characters follow with no gap. A rectangle is held one stage
// until the walker finds the next rectangle of the same character or reaches
// the end of the glyph; an accepted character passes through the job queue,
// the walker's job register, that stage and the output register, and a
// queued character waits for those ahead. A two-deep job queue decouples the
// input from the walker; in_stall rises only when that queue is full. When
// out_stall is high the walker keeps going until a second rectangle is ready,
// then holds. Reset clears the cursor to 0,0, empties the queue and the
// output, and loads the registers with width 240, height 320, white on black,
// scale 1. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
module text_cursor_glyph_renderer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic [7:0]                        char_code,
	input  logic signed [tcgr_pkg::CUR_W-1:0] set_x,
	input  logic signed [tcgr_pkg::CUR_W-1:0] set_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [8:0]                        rect_x,
	output logic [8:0]                        rect_y,
	output logic [3:0]                        rect_w,
	output logic [3:0]                        rect_h,
	output logic [15:0]                       color,
	output logic signed [tcgr_pkg::CUR_W-1:0] cursor_col_after,
	output logic signed [tcgr_pkg::CUR_W-1:0] cursor_row_after,
	output logic                              last
);
	import tcgr_pkg::*;

	cfg_t  cfg_q;
	logic  jobq_push;
	job_t  jobq_push_data;
	logic  jobq_pop;
	job_t  jobq_head;
	logic  jobq_full;
	logic  jobq_empty;
	rect_t out_rect;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_w    <= PANEL_WIDTH;
			cfg_q.active_h    <= PANEL_HEIGHT;
			cfg_q.fg_color    <= FG_RESET;
			cfg_q.paper_color <= BG_RESET;
			cfg_q.scale       <= SCALE_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ACTIVE_W: begin
					cfg_q.active_w <= cfg_data[8:0];
				end
				REG_ACTIVE_H: begin
					cfg_q.active_h <= cfg_data[8:0];
				end
				REG_FG_COLOR: begin
					cfg_q.fg_color <= cfg_data;
				end
				REG_PAPER_COLOR: begin
					cfg_q.paper_color <= cfg_data;
				end
				REG_SCALE: begin
					cfg_q.scale <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front: accept, classify, move the cursor
	tcgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.char_code (char_code),
		.set_x     (set_x),
		.set_y     (set_y),
		.jobq_full (jobq_full),
		.jobq_push (jobq_push),
		.jobq_data (jobq_push_data)
	);

	// Job queue
	tcgr_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (jobq_push),
		.push_data (jobq_push_data),
		.pop       (jobq_pop),
		.head      (jobq_head),
		.full      (jobq_full),
		.empty     (jobq_empty)
	);

	// Back: walk the glyph cells and emit rectangles
	tcgr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.jobq_empty (jobq_empty),
		.jobq_head  (jobq_head),
		.jobq_pop   (jobq_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_rect   (out_rect)
	);

	assign rect_x           = out_rect.x;
	assign rect_y           = out_rect.y;
	assign rect_w           = out_rect.w;
	assign rect_h           = out_rect.h;
	assign color            = out_rect.color;
	assign cursor_col_after = out_rect.col_after;
	assign cursor_row_after = out_rect.row_after;
	assign last             = out_rect.last;

endmodule
